/* design/png_chunk_stream_walker_defines.svh */
// Assertion macros for the PNG chunk stream walker.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef PNG_CHUNK_STREAM_WALKER_DEFINES_SVH
`define PNG_CHUNK_STREAM_WALKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCSW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked out of reset.
`define PCSW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

/* design/pcsw_pkg.sv */
// Shared types and constants for the PNG chunk stream walker.
// No dependencies.
package pcsw_pkg;

  // Section / phase codes
  localparam logic [2:0] SEC_SIG    = 3'd0;
  localparam logic [2:0] SEC_LENGTH = 3'd1;
  localparam logic [2:0] SEC_TYPE   = 3'd2;
  localparam logic [2:0] SEC_DATA   = 3'd3;
  localparam logic [2:0] SEC_CRC    = 3'd4;
  localparam logic [2:0] SEC_IGNORE = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SIG_BAD  = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;

  // Chunk types, first byte in the low 8 bits
  localparam logic [31:0] TYPE_IEND = 32'h444E4549;
  localparam logic [31:0] TYPE_IHDR = 32'h52444849;

  localparam logic [7:0] SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                          8'd13, 8'd10, 8'd26, 8'd10};

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  section;
    logic        chunk_last;
    logic        insert_point;
    logic        final_chunk;
    logic [31:0] chunk_length;
    logic [1:0]  status;
  } pcsw_res_t;

endpackage

/* design/pcsw_walker.sv */
// Chunk walker state and per-byte labelling logic.
// Depends on pcsw_pkg.
module pcsw_walker import pcsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  output pcsw_res_t  res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  field_count_q, field_count_d;
  logic [31:0] length_q, length_d;
  logic [31:0] data_left_q, data_left_d;
  logic [31:0] type_q, type_d;
  logic        sig_bad_q, sig_bad_d;
  logic        is_end_q, is_end_d;
  logic        finished_q, finished_d;
  logic        field_done;
  logic [2:0]  field_next;

  assign field_done = (field_count_q[1:0] == 2'b11);
  assign field_next = {1'b0, field_count_q[1:0] + 2'd1};

  always_comb begin
    phase_d       = phase_q;
    field_count_d = field_count_q;
    length_d      = length_q;
    data_left_d   = data_left_q;
    type_d        = type_q;
    sig_bad_d     = sig_bad_q;
    is_end_d      = is_end_q;
    finished_d    = finished_q;

    res_o              = '0;
    res_o.byte_out     = data_byte_i;
    res_o.section      = phase_q;
    res_o.status       = ST_OK;

    unique case (phase_q)
      SEC_SIG: begin
        if (data_byte_i != SIG_BYTES[field_count_q]) begin
          sig_bad_d = 1'b1;
        end
        if (field_count_q == 3'd7) begin
          res_o.status  = sig_bad_d ? ST_SIG_BAD : ST_OK;
          phase_d       = sig_bad_d ? SEC_IGNORE : SEC_LENGTH;
          field_count_d = '0;
        end else begin
          field_count_d = field_count_q + 3'd1;
        end
      end
      SEC_LENGTH: begin
        length_d = {length_q[23:0], data_byte_i};
        if (field_done) begin
          data_left_d   = length_d;
          phase_d       = SEC_TYPE;
          field_count_d = '0;
        end else begin
          field_count_d = field_next;
        end
      end
      SEC_TYPE: begin
        type_d             = {data_byte_i, type_q[31:8]};
        res_o.chunk_length = length_q;
        if (field_done) begin
          is_end_d          = (type_d == TYPE_IEND);
          res_o.final_chunk = is_end_d;
          phase_d           = (data_left_q != '0) ? SEC_DATA : SEC_CRC;
          field_count_d     = '0;
        end else begin
          field_count_d = field_next;
        end
      end
      SEC_DATA: begin
        res_o.chunk_length = length_q;
        res_o.final_chunk  = is_end_q;
        data_left_d        = data_left_q - 32'd1;
        if (data_left_d == '0) begin
          phase_d = SEC_CRC;
        end
      end
      SEC_CRC: begin
        res_o.chunk_length = length_q;
        res_o.final_chunk  = is_end_q;
        if (field_done) begin
          res_o.chunk_last   = 1'b1;
          res_o.insert_point = (type_q == TYPE_IHDR);
          field_count_d      = '0;
          if (is_end_q) begin
            finished_d = 1'b1;
            phase_d    = SEC_IGNORE;
          end else begin
            phase_d = SEC_LENGTH;
          end
        end else begin
          field_count_d = field_next;
        end
      end
      default: begin
        // the ignore section and any unreachable codes are handled here
        res_o.section = SEC_IGNORE;
        res_o.status  = sig_bad_q ? ST_SIG_BAD : ST_FINISHED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= SEC_SIG;
      field_count_q <= '0;
      length_q      <= '0;
      data_left_q   <= '0;
      type_q        <= '0;
      sig_bad_q     <= 1'b0;
      is_end_q      <= 1'b0;
      finished_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      field_count_q <= field_count_d;
      length_q      <= length_d;
      data_left_q   <= data_left_d;
      type_q        <= type_d;
      sig_bad_q     <= sig_bad_d;
      is_end_q      <= is_end_d;
      finished_q    <= finished_d;
    end
  end

endmodule

/* design/png_chunk_stream_walker.sv */
// The labelled result of an accepted byte is registered and shown in the next cycle.
// Throughput: one byte per cycle while out_ready_i does not stall a held result; the
// walker state updates in the accept cycle and the result register frees as soon as its request is taken.
// Reset (rst_ni low, async): back to the signature section, all counters,
// flags and the result valid cleared.
// Top level of the PNG chunk stream walker; depends on pcsw_pkg,
// pcsw_walker and png_chunk_stream_walker_defines.svh.
`include "png_chunk_stream_walker_defines.svh"

module png_chunk_stream_walker import pcsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  section_o,
  output logic        chunk_last_o,
  output logic        insert_point_o,
  output logic        final_chunk_o,
  output logic [31:0] chunk_length_o,
  output logic [1:0]  status_o
);

  pcsw_res_t res;
  pcsw_res_t res_q;
  logic      out_valid_q;
  logic      in_accept;

  // Take a new request whenever the result slot is empty or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  pcsw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = res_q.byte_out;
  assign section_o      = res_q.section;
  assign chunk_last_o   = res_q.chunk_last;
  assign insert_point_o = res_q.insert_point;
  assign final_chunk_o  = res_q.final_chunk;
  assign chunk_length_o = res_q.chunk_length;
  assign status_o       = res_q.status;

  `PCSW_ASSERT_NXT(a_accept_gives_result, in_valid_i && in_ready_o, out_valid_o)
  `PCSW_ASSERT_IMP(a_insert_on_last, out_valid_o && insert_point_o,
                   chunk_last_o && (section_o == SEC_CRC))
  `PCSW_ASSERT_IMP(a_last_in_crc, out_valid_o && chunk_last_o, section_o == SEC_CRC)
  `PCSW_ASSERT_IMP(a_finished_ignored, out_valid_o && (status_o == ST_FINISHED),
                   (section_o == SEC_IGNORE) && !chunk_last_o && !final_chunk_o)

endmodule
